>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define MBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants of the multichannel burst scheduler.
// ----------------------------------------------------------------------------
package mbs_pkg;

  // Default sizes.
  localparam int CHANNELS_DEF  = 4;
  localparam int MAX_SHOTS_DEF = 15;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Width of the per-channel countdown and of the status mask.
  localparam int CD_W   = 24;
  localparam int MASK_W = 4;

  // Reset values.
  localparam logic [15:0]        INTERVAL_RESET = 16'd410;
  localparam logic signed [15:0] DIR_X_RESET    = 16'sd16384;

  // Input opcodes.
  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  // Classified command kinds.
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_kind_t;

  // One command in the queue. For a load, data_x/data_y are the offset;
  // for a tick they are the base position.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         chan;
    logic [3:0]         shots;
    logic signed [15:0] data_x;
    logic signed [15:0] data_y;
    logic signed [15:0] aim_x;
    logic signed [15:0] aim_y;
    logic [14:0]        dt;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic               fire_valid;
    logic [2:0]         fire_channel;
    logic signed [15:0] spawn_x;
    logic signed [15:0] spawn_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [MASK_W-1:0]  active_mask;
    logic               last;
  } res_t;

endpackage

>>> hdl/mbs_if.sv
// ----------------------------------------------------------------------------
// mbs_if
// Valid/ready stream interfaces for the input items and the result beats.
// ----------------------------------------------------------------------------
interface mbs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [2:0]         channel;
  logic [3:0]         burst_len;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic signed [15:0] aim_x;
  logic signed [15:0] aim_y;
  logic signed [15:0] tick_delta;
  logic signed [15:0] base_x;
  logic signed [15:0] base_y;

  modport source (
    output valid, opcode, channel, burst_len, offset_x, offset_y, aim_x, aim_y,
           tick_delta, base_x, base_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, burst_len, offset_x, offset_y, aim_x, aim_y,
           tick_delta, base_x, base_y,
    output ready
  );
endinterface

interface mbs_out_if;
  logic               valid;
  logic               ready;
  logic               fire_valid;
  logic [2:0]         fire_channel;
  logic signed [15:0] spawn_x;
  logic signed [15:0] spawn_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic [3:0]         active_mask;
  logic               last;

  modport source (
    output valid, fire_valid, fire_channel, spawn_x, spawn_y, dir_x, dir_y,
           active_mask, last,
    input  ready
  );
  modport sink (
    input  valid, fire_valid, fire_channel, spawn_x, spawn_y, dir_x, dir_y,
           active_mask, last,
    output ready
  );
endinterface

>>> hdl/mbs_front.sv
// ----------------------------------------------------------------------------
// mbs_front
// Accepts input beats and classifies them into queue commands.
// ----------------------------------------------------------------------------
module mbs_front #(
  parameter int CHANNELS  = mbs_pkg::CHANNELS_DEF,
  parameter int MAX_SHOTS = mbs_pkg::MAX_SHOTS_DEF
) (
  mbs_in_if.sink         in_bus,
  input  logic           q_full,
  output logic           q_push,
  output mbs_pkg::cmd_t  q_cmd
);

  logic sched_ok;

  // Take a beat whenever the queue has room.
  assign in_bus.ready = !q_full;
  assign q_push       = in_bus.valid && !q_full;

  // A schedule counts only for an existing channel and a nonzero count.
  assign sched_ok = (4'(in_bus.channel) < 4'(CHANNELS)) && (in_bus.burst_len != 4'd0);

  // Classify the opcode and pack the fields the back end needs.
  always_comb begin
    q_cmd.chan   = in_bus.channel;
    q_cmd.shots  = (in_bus.burst_len > 4'(MAX_SHOTS)) ? 4'(MAX_SHOTS) : in_bus.burst_len;
    q_cmd.aim_x  = in_bus.aim_x;
    q_cmd.aim_y  = in_bus.aim_y;
    q_cmd.dt     = in_bus.tick_delta[15] ? 15'd0 : in_bus.tick_delta[14:0];
    q_cmd.data_x = in_bus.offset_x;
    q_cmd.data_y = in_bus.offset_y;
    case (in_bus.opcode)
      mbs_pkg::OP_SCHEDULE: begin
        q_cmd.kind = sched_ok ? mbs_pkg::CMD_LOAD : mbs_pkg::CMD_NOP;
      end
      mbs_pkg::OP_TICK: begin
        q_cmd.kind   = mbs_pkg::CMD_TICK;
        q_cmd.data_x = in_bus.base_x;
        q_cmd.data_y = in_bus.base_y;
      end
      mbs_pkg::OP_CLEAR: begin
        q_cmd.kind = mbs_pkg::CMD_CLEAR;
      end
      default: begin
        q_cmd.kind = mbs_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

>>> hdl/mbs_queue.sv
// ----------------------------------------------------------------------------
// mbs_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mbs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output mbs_pkg::cmd_t pop_cmd,
  output logic          empty
);

  localparam int DEPTH = mbs_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mbs_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  // Pointer and fill-count update; pointers wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hdl/mbs_back.sv
// ----------------------------------------------------------------------------
// mbs_back
// Burst state, channel walk and result generation for queued commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbs_back #(
  parameter int CHANNELS = mbs_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  logic          q_empty,
  input  mbs_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output mbs_pkg::res_t out_res
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CD_W   = mbs_pkg::CD_W;
  localparam int MASK_N = (CHANNELS < mbs_pkg::MASK_W) ? CHANNELS : mbs_pkg::MASK_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUB  = 4'b0010,
    S_FIRE = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // Burst state per channel.
  logic [3:0]             rem_r  [CHANNELS];
  logic signed [CD_W-1:0] cd_r   [CHANNELS];
  logic signed [15:0]     offx_r [CHANNELS];
  logic signed [15:0]     offy_r [CHANNELS];
  logic signed [15:0]     dirx_r [CHANNELS];
  logic signed [15:0]     diry_r [CHANNELS];

  logic [15:0]     cfg_r;
  state_t          state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  mbs_pkg::cmd_t   cmd_r, cmd_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  mbs_pkg::res_t   pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  mbs_pkg::res_t   out_r, out_nxt;

  logic [15:0]                iv;
  logic signed [CD_W-1:0]     iv_ext, dt_ext, cur_cd;
  logic [3:0]                 cur_rem;
  logic [CH_W-1:0]            ld_idx;
  logic                       out_free, fire_now, can_fire, last_ch;
  logic [mbs_pkg::MASK_W-1:0] mask_now, mask_fire;
  mbs_pkg::res_t              fire_res;

  function automatic logic signed [15:0] sat_add16(logic signed [15:0] a,
                                                   logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      return s[16] ? 16'sh8000 : 16'sh7FFF;
    end
    return s[15:0];
  endfunction

  // A zero interval behaves as one.
  assign iv     = (cfg_r == 16'd0) ? 16'd1 : cfg_r;
  assign iv_ext = $signed(CD_W'(iv));
  assign dt_ext = $signed(CD_W'(cmd_r.dt));

  assign cur_rem  = rem_r[ch_r];
  assign cur_cd   = cd_r[ch_r];
  assign ld_idx   = q_cmd.chan[CH_W-1:0];
  assign out_free = !out_valid_r || out_ready;
  assign last_ch  = (ch_r == CH_W'(CHANNELS - 1));
  assign q_pop    = (state_r == S_IDLE) && !q_empty;

  // A shot is due while shots remain and the countdown is not positive.
  assign fire_now = (state_r == S_FIRE) && (cur_rem != 4'd0) &&
                    (cur_cd[CD_W-1] || (cur_cd == '0));
  // A held shot must leave through the output register first.
  assign can_fire = fire_now && (!pend_valid_r || out_free);

  // Active mask now, and as it will read once the current shot is counted.
  always_comb begin
    mask_now  = '0;
    mask_fire = '0;
    for (int c = 0; c < MASK_N; c++) begin
      mask_now[c]  = (rem_r[c] != 4'd0);
      mask_fire[c] = (CH_W'(c) == ch_r) ? (cur_rem != 4'd1) : (rem_r[c] != 4'd0);
    end
  end

  // Result beat for the shot being fired.
  always_comb begin
    fire_res.fire_valid   = 1'b1;
    fire_res.fire_channel = 3'(ch_r);
    fire_res.spawn_x      = sat_add16(cmd_r.data_x, offx_r[ch_r]);
    fire_res.spawn_y      = sat_add16(cmd_r.data_y, offy_r[ch_r]);
    fire_res.dir_x        = dirx_r[ch_r];
    fire_res.dir_y        = diry_r[ch_r];
    fire_res.active_mask  = mask_fire;
    fire_res.last         = 1'b0;
  end

  // Sequencer. A fired shot is held back one step so the final one of a
  // tick can be flagged as last.
  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    cmd_nxt        = cmd_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          cmd_nxt   = q_cmd;
          ch_nxt    = '0;
          state_nxt = (q_cmd.kind == mbs_pkg::CMD_TICK) ? S_SUB : S_DONE;
        end
      end
      S_SUB: begin
        state_nxt = S_FIRE;
      end
      S_FIRE: begin
        if (fire_now) begin
          if (can_fire) begin
            if (pend_valid_r) begin
              out_nxt       = pend_r;
              out_valid_nxt = 1'b1;
            end
            pend_nxt       = fire_res;
            pend_valid_nxt = 1'b1;
          end
        end else if (last_ch) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_SUB;
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (pend_valid_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt             = '0;
            out_nxt.active_mask = mask_now;
          end
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ch_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cfg_r        <= mbs_pkg::INTERVAL_RESET;
    end else begin
      state_r      <= state_nxt;
      ch_r         <= ch_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // Burst state: load, clear, time step and shot countdown.
  always_ff @(posedge clk) begin
    if (!rst_n || (q_pop && (q_cmd.kind == mbs_pkg::CMD_CLEAR))) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rem_r[c]  <= 4'd0;
        cd_r[c]   <= '0;
        offx_r[c] <= '0;
        offy_r[c] <= '0;
        dirx_r[c] <= mbs_pkg::DIR_X_RESET;
        diry_r[c] <= '0;
      end
    end else if (q_pop && (q_cmd.kind == mbs_pkg::CMD_LOAD)) begin
      rem_r[ld_idx]  <= q_cmd.shots;
      cd_r[ld_idx]   <= iv_ext;
      offx_r[ld_idx] <= q_cmd.data_x;
      offy_r[ld_idx] <= q_cmd.data_y;
      dirx_r[ld_idx] <= q_cmd.aim_x;
      diry_r[ld_idx] <= q_cmd.aim_y;
    end else if ((state_r == S_SUB) && (cur_rem != 4'd0)) begin
      cd_r[ch_r] <= cur_cd - dt_ext;
    end else if (can_fire) begin
      rem_r[ch_r] <= cur_rem - 4'd1;
      cd_r[ch_r]  <= cur_cd + iv_ext;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Checks.
  `MBS_ASSERT(a_pop_idle, clk, rst_n, q_pop |-> (state_r == S_IDLE), "pop outside idle")
  `MBS_ASSERT(a_idle_no_pend, clk, rst_n, (state_r == S_IDLE) |-> !pend_valid_r, "held shot in idle")
  `MBS_ASSERT(a_fire_chan, clk, rst_n, (out_valid_r && out_r.fire_valid) |-> ({1'b0, out_r.fire_channel} < 4'(CHANNELS)), "bad fire channel")
  `MBS_ASSERT(a_fire_hold, clk, rst_n, (fire_now && pend_valid_r && !out_free) |=> (state_r == S_FIRE), "stalled shot dropped")

endmodule

>>> hdl/multichannel_burst_scheduler.sv
// ----------------------------------------------------------------------------
// multichannel_burst_scheduler
// Keeps one burst per channel and emits one result beat per fired shot.
// A schedule or clear item (and an unused opcode) passes through the back
// end's idle and done states and yields one status beat. A tick walks the
// channels in order, a subtract and a fire state for each, with up to
// CHANNELS*MAX_SHOTS shot beats. The front end keeps taking items into a
// four-entry command queue while the back end works, and a result register
// lets the next beat be prepared while the previous one waits on out_bus.ready.
// ----------------------------------------------------------------------------
module multichannel_burst_scheduler #(
  parameter int CHANNELS  = mbs_pkg::CHANNELS_DEF,
  parameter int MAX_SHOTS = mbs_pkg::MAX_SHOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mbs_in_if.sink      in_bus,
  mbs_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic          q_push, q_full, q_pop, q_empty;
  mbs_pkg::cmd_t push_cmd, pop_cmd;
  logic          res_valid;
  mbs_pkg::res_t res;

  // Front end: accept and classify.
  mbs_front #(
    .CHANNELS  (CHANNELS),
    .MAX_SHOTS (MAX_SHOTS)
  ) u_front (
    .in_bus (in_bus),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  // Command queue.
  mbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // Back end: burst state and result generation.
  mbs_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (res_valid),
    .out_ready (out_bus.ready),
    .out_res   (res)
  );

  // Result beat onto the output channel.
  assign out_bus.valid        = res_valid;
  assign out_bus.fire_valid   = res.fire_valid;
  assign out_bus.fire_channel = res.fire_channel;
  assign out_bus.spawn_x      = res.spawn_x;
  assign out_bus.spawn_y      = res.spawn_y;
  assign out_bus.dir_x        = res.dir_x;
  assign out_bus.dir_y        = res.dir_y;
  assign out_bus.active_mask  = res.active_mask;
  assign out_bus.last         = res.last;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Burst scheduler testbench
// Drives schedule, tick, clear and unused-opcode items into the scheduler,
// predicts every result beat from its own copy of the burst state, and
// checks each beat field by field. Both stream sides idle at random. There
// is one long receiver hold and there are pauses that let the block drain.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH     = mbs_pkg::CHANNELS_DEF;
  localparam int MAX_SHOTS  = mbs_pkg::MAX_SHOTS_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles to let the back end settle after the last expected beat.
  localparam int SETTLE_CYCLES  = 4 * (2 + 2 * NUM_CH);
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT =
    HOLD_CYCLES + 4 * (SETTLE_CYCLES + 2 + 2 * NUM_CH + NUM_CH * MAX_SHOTS * 16);

  // One input item as the testbench builds it.
  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         channel;
    logic [3:0]         burst_len;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] aim_x;
    logic signed [15:0] aim_y;
    logic signed [15:0] tick_delta;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
  } burst_item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  mbs_in_if  in_bus ();
  mbs_out_if out_bus ();

  multichannel_burst_scheduler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted burst state and the beats still owed by the block.
  logic [3:0]         shots_left [NUM_CH];
  int                 burst_clock [NUM_CH];
  logic signed [15:0] burst_off_x [NUM_CH];
  logic signed [15:0] burst_off_y [NUM_CH];
  logic signed [15:0] burst_dir_x [NUM_CH];
  logic signed [15:0] burst_dir_y [NUM_CH];
  logic [15:0]        interval_reg;
  mbs_pkg::res_t      beats_due [$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int hold_request   = 0;
  bit idle_on        = 1'b1;

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Burst state helpers.
  function automatic void clear_bursts();
    for (int c = 0; c < NUM_CH; c++) begin
      shots_left[c]  = '0;
      burst_clock[c] = 0;
      burst_off_x[c] = '0;
      burst_off_y[c] = '0;
      burst_dir_x[c] = mbs_pkg::DIR_X_RESET;
      burst_dir_y[c] = '0;
    end
  endfunction

  function automatic logic [mbs_pkg::MASK_W-1:0] live_mask();
    logic [mbs_pkg::MASK_W-1:0] mask;
    mask = '0;
    for (int c = 0; c < NUM_CH && c < mbs_pkg::MASK_W; c++)
      if (shots_left[c] != 0) mask[c] = 1'b1;
    return mask;
  endfunction

  function automatic logic signed [15:0] clip16(input int value);
    if (value > 32767) return 16'sd32767;
    if (value < -32768) return -16'sd32768;
    return 16'(value);
  endfunction

  // Applies one accepted item to the burst state and queues its beats.
  function automatic void advance_bursts(input burst_item_t item);
    int            step;
    int            elapsed;
    int            cnt;
    mbs_pkg::res_t beat;
    mbs_pkg::res_t item_beats [$];
    step = (interval_reg == 0) ? 1 : int'(interval_reg);
    case (item.opcode)
      mbs_pkg::OP_SCHEDULE: begin
        if (item.channel < NUM_CH && item.burst_len != 0) begin
          cnt = (item.burst_len > MAX_SHOTS) ? MAX_SHOTS : int'(item.burst_len);
          shots_left[item.channel]  = 4'(cnt);
          burst_clock[item.channel] = step;
          burst_off_x[item.channel] = item.offset_x;
          burst_off_y[item.channel] = item.offset_y;
          burst_dir_x[item.channel] = item.aim_x;
          burst_dir_y[item.channel] = item.aim_y;
        end
      end
      mbs_pkg::OP_TICK: begin
        elapsed = int'(item.tick_delta);
        if (elapsed < 0) elapsed = 0;
        for (int c = 0; c < NUM_CH; c++) begin
          if (shots_left[c] != 0) begin
            burst_clock[c] -= elapsed;
            // Fire while the countdown has run out and shots remain.
            while (shots_left[c] != 0 && burst_clock[c] <= 0) begin
              shots_left[c]  = shots_left[c] - 1'b1;
              burst_clock[c] += step;
              beat              = '0;
              beat.fire_valid   = 1'b1;
              beat.fire_channel = 3'(c);
              beat.spawn_x      = clip16(int'(item.base_x) + int'(burst_off_x[c]));
              beat.spawn_y      = clip16(int'(item.base_y) + int'(burst_off_y[c]));
              beat.dir_x        = burst_dir_x[c];
              beat.dir_y        = burst_dir_y[c];
              beat.active_mask  = live_mask();
              item_beats.push_back(beat);
            end
          end
        end
      end
      mbs_pkg::OP_CLEAR: clear_bursts();
      default: ;
    endcase
    // Items that fire nothing report a status beat.
    if (item_beats.size() == 0) begin
      beat             = '0;
      beat.active_mask = live_mask();
      item_beats.push_back(beat);
    end
    item_beats[item_beats.size() - 1].last = 1'b1;
    foreach (item_beats[i]) beats_due.push_back(item_beats[i]);
  endfunction

  // Item builders: fields that the operation does not use stay random.
  function automatic burst_item_t noise_fields();
    burst_item_t item;
    item.opcode     = 2'($urandom);
    item.channel    = 3'($urandom);
    item.burst_len  = 4'($urandom);
    item.offset_x   = 16'($urandom);
    item.offset_y   = 16'($urandom);
    item.aim_x      = 16'($urandom);
    item.aim_y      = 16'($urandom);
    item.tick_delta = 16'($urandom);
    item.base_x     = 16'($urandom);
    item.base_y     = 16'($urandom);
    return item;
  endfunction

  function automatic burst_item_t schedule_item(input int chan, input int count,
      input logic signed [15:0] ox, input logic signed [15:0] oy,
      input logic signed [15:0] ax, input logic signed [15:0] ay);
    burst_item_t item;
    item            = noise_fields();
    item.opcode     = mbs_pkg::OP_SCHEDULE;
    item.channel    = 3'(chan);
    item.burst_len  = 4'(count);
    item.offset_x   = ox;
    item.offset_y   = oy;
    item.aim_x      = ax;
    item.aim_y      = ay;
    return item;
  endfunction

  function automatic burst_item_t tick_item(input logic signed [15:0] dt,
      input logic signed [15:0] bx, input logic signed [15:0] by);
    burst_item_t item;
    item            = noise_fields();
    item.opcode     = mbs_pkg::OP_TICK;
    item.tick_delta = dt;
    item.base_x     = bx;
    item.base_y     = by;
    return item;
  endfunction

  function automatic burst_item_t opcode_item(input logic [1:0] op);
    burst_item_t item;
    item        = noise_fields();
    item.opcode = op;
    return item;
  endfunction

  // Mostly valid schedules and ticks sized to the interval, some noise.
  function automatic burst_item_t random_item();
    burst_item_t item;
    int step;
    int dt_max;
    int pick;
    item   = noise_fields();
    step   = (interval_reg == 0) ? 1 : int'(interval_reg);
    dt_max = (2 * step > 32767) ? 32767 : 2 * step;
    pick   = $urandom_range(0, 99);
    if (pick < 40) begin
      item.opcode    = mbs_pkg::OP_SCHEDULE;
      item.channel   = 3'($urandom_range(0, NUM_CH - 1));
      item.burst_len = 4'($urandom_range(1, MAX_SHOTS));
    end else if (pick < 80) begin
      item.opcode = mbs_pkg::OP_TICK;
      if ($urandom_range(0, 7) != 0) item.tick_delta = 16'($urandom_range(0, dt_max));
    end else if (pick < 87) begin
      item.opcode = mbs_pkg::OP_SCHEDULE;
    end else if (pick < 93) begin
      item.opcode = mbs_pkg::OP_CLEAR;
    end else begin
      item.opcode = OP_UNUSED;
    end
    return item;
  endfunction

  // Offers one item, with an optional random gap first, and waits for the beat.
  task automatic send_item(input burst_item_t item, input bit allow_gap);
    if (allow_gap && idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= item.opcode;
    in_bus.channel    <= item.channel;
    in_bus.burst_len  <= item.burst_len;
    in_bus.offset_x   <= item.offset_x;
    in_bus.offset_y   <= item.offset_y;
    in_bus.aim_x      <= item.aim_x;
    in_bus.aim_y      <= item.aim_y;
    in_bus.tick_delta <= item.tick_delta;
    in_bus.base_x     <= item.base_x;
    in_bus.base_y     <= item.base_y;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    advance_bursts(item);
  endtask

  // Stops offering items until every owed beat has arrived.
  task automatic wait_results_done();
    in_bus.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_interval(input logic [15:0] value);
    wait_results_done();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    interval_reg = value;
  endtask

  // Status-only items: empty tick, clear, unused opcode, ignored schedules.
  task automatic test_status_items();
    send_item(tick_item(16'sd0, 16'($urandom), 16'($urandom)), 1'b1);
    send_item(opcode_item(mbs_pkg::OP_CLEAR), 1'b1);
    send_item(opcode_item(OP_UNUSED), 1'b1);
    send_item(schedule_item(5, 7, 16'sd100, 16'sd100, 16'sd0, 16'sd0), 1'b1);
    send_item(schedule_item(2, 0, 16'sd100, 16'sd100, 16'sd0, 16'sd0), 1'b1);
  endtask

  // Field extremes, a reschedule, negative delta and saturated spawn points.
  task automatic test_burst_extremes();
    send_item(schedule_item(0, MAX_SHOTS, 16'sd32767, 16'sd32767,
                            -16'sd32768, 16'sd32767), 1'b1);
    send_item(schedule_item(1, MAX_SHOTS, -16'sd32768, -16'sd32768,
                            16'sd32767, -16'sd32768), 1'b1);
    send_item(schedule_item(3, 1, 16'sd0, 16'sd0, 16'sd0, 16'sd0), 1'b1);
    send_item(schedule_item(7, MAX_SHOTS, -16'sd1, -16'sd1, -16'sd1, -16'sd1), 1'b1);
    send_item(schedule_item(3, 2, -16'sd1, 16'sd1, mbs_pkg::DIR_X_RESET, -16'sd1), 1'b1);
    send_item(tick_item(-16'sd32768, 16'sd0, 16'sd0), 1'b1);
    send_item(tick_item(16'(int'(interval_reg) - 1), 16'sd1, 16'sd1), 1'b1);
    send_item(tick_item(16'sd1, 16'sd32767, -16'sd32768), 1'b1);
    send_item(tick_item(16'sd32767, -16'sd32768, 16'sd32767), 1'b1);
  endtask

  // Every channel fires every shot in one tick, then a clear of a live burst.
  task automatic test_full_volley();
    for (int c = 0; c < NUM_CH; c++)
      send_item(schedule_item(c, MAX_SHOTS, 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom)), 1'b1);
    send_item(tick_item(16'sd32767, 16'($urandom), 16'($urandom)), 1'b1);
    send_item(schedule_item(2, 5, 16'sd0, 16'sd0, 16'sd0, 16'sd0), 1'b1);
    send_item(opcode_item(mbs_pkg::OP_CLEAR), 1'b1);
    send_item(tick_item(16'sd32767, 16'sd0, 16'sd0), 1'b1);
  endtask

  // Random traffic under several intervals, the extremes among them.
  task automatic test_interval_sweep();
    logic [15:0] settings [5];
    settings = '{16'd1, 16'd0, 16'd65535, 16'd0, mbs_pkg::INTERVAL_RESET};
    settings[3] = 16'($urandom_range(50, 3000));
    foreach (settings[p]) begin
      set_interval(settings[p]);
      repeat (12) send_item(random_item(), 1'b1);
    end
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    repeat (14) send_item(random_item(), 1'b0);
  endtask

  // The sender waits for the block to drain between short runs.
  task automatic test_drain_pause();
    repeat (2) begin
      repeat (6) send_item(random_item(), 1'b1);
      wait_results_done();
    end
  endtask

  // Closing stretch with neither side idling.
  task automatic test_final_run();
    idle_on = 1'b0;
    repeat (20) send_item(random_item(), 1'b0);
  endtask

  // Result sink: random stall bursts and the long hold, counted here.
  initial begin
    int stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 15);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic void compare_field(input string name, input logic [15:0] want,
      input logic [15:0] got, input bit is_signed);
    if (got !== want) begin
      mismatch_count++;
      if (is_signed)
        $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      else
        $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // Each result beat is checked against the oldest owed beat.
  always @(posedge clk) begin
    mbs_pkg::res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (beats_due.size() == 0) begin
        mismatch_count++;
        $error("result beat arrived with none expected");
      end else begin
        want = beats_due.pop_front();
        compare_field("fire_valid", 16'(want.fire_valid), 16'(out_bus.fire_valid), 1'b0);
        compare_field("fire_channel", 16'(want.fire_channel),
                      16'(out_bus.fire_channel), 1'b0);
        compare_field("spawn_x", want.spawn_x, out_bus.spawn_x, 1'b1);
        compare_field("spawn_y", want.spawn_y, out_bus.spawn_y, 1'b1);
        compare_field("dir_x", want.dir_x, out_bus.dir_x, 1'b1);
        compare_field("dir_y", want.dir_y, out_bus.dir_y, 1'b1);
        compare_field("active_mask", 16'(want.active_mask),
                      16'(out_bus.active_mask), 1'b0);
        compare_field("last", 16'(want.last), 16'(out_bus.last), 1'b0);
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Reset, then the tests in turn, then the final verdict.
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = mbs_pkg::INTERVAL_RESET;
    in_bus.valid      = 1'b0;
    in_bus.opcode     = mbs_pkg::OP_CLEAR;
    in_bus.channel    = '0;
    in_bus.burst_len  = '0;
    in_bus.offset_x   = '0;
    in_bus.offset_y   = '0;
    in_bus.aim_x      = '0;
    in_bus.aim_y      = '0;
    in_bus.tick_delta = '0;
    in_bus.base_x     = '0;
    in_bus.base_y     = '0;
    interval_reg      = mbs_pkg::INTERVAL_RESET;
    clear_bursts();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_status_items();
    test_burst_extremes();
    test_full_volley();
    test_interval_sweep();
    test_backpressure();
    test_drain_pause();
    test_final_run();

    wait_results_done();
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
